>>> src/stca_pkg.sv
// Shared types and constants of the truncated absolute-difference cost block.
// Holds the request and result structs, the command passed from front to back,
// configuration register codes and the sequencer state type. No dependencies.
package stca_pkg;

    localparam int PIX_W      = 8;
    localparam int DISP_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int LWIDTH_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [PIX_W-1:0]    THRESHOLD_RST  = 8'd20;
    localparam logic [COUNT_W-1:0]  DISP_COUNT_RST = 7'd64;
    localparam logic [LWIDTH_W-1:0] LINE_WIDTH_RST = 13'd640;

    localparam logic [DISP_W-1:0] NEAR_COL_MAX = 6'd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 2'd0,
        CFG_DISP_COUNT = 2'd1,
        CFG_LINE_WIDTH = 2'd2
    } cfg_index_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [PIX_W-1:0] left_pixel;
        logic [PIX_W-1:0] right_pixel;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]  cost;
        logic [DISP_W-1:0] disparity;
        logic              last_of_pixel;
    } out_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   left_pixel;
        logic [PIX_W-1:0]   right_pixel;
        logic [DISP_W-1:0]  slot;
        logic [DISP_W-1:0]  near_col;
        logic [COUNT_W-1:0] count;
        logic               first_col;
    } cmd_t;

endpackage

>>> src/stca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/stca_fifo.sv
// Small first-in first-out queue of packed words, power-of-two depth.
// No dependencies.
module stca_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH):0]     count
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign count   = count_reg;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> src/stca_front.sv
// Front part: configuration registers, column and history slot counters, and
// classification of each request into a command. Depends on stca_pkg.
module stca_front
    import stca_pkg::*;
#(
    parameter int MAX_DISP  = 64,
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  in_item_t              in_item,
    output cmd_t                  cmd,
    output logic [PIX_W-1:0]      threshold
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > LWIDTH_W) ? WW : LWIDTH_W;

    logic [PIX_W-1:0]    threshold_reg;
    logic [COUNT_W-1:0]  disp_count_reg;
    logic [LWIDTH_W-1:0] line_width_reg;
    logic [CW-1:0]       column_reg;
    logic [DISP_W-1:0]   slot_reg;
    logic [CW-1:0]       column_next;
    logic [DISP_W-1:0]   slot_next;
    logic [EW-1:0]       eff_width;
    logic [EW-1:0]       col_inc;
    logic [COUNT_W-1:0]  eff_count;

    always_comb
    begin
        eff_width = EW'(line_width_reg);
        if (line_width_reg == '0)
        begin
            eff_width = EW'(1);
        end
        else if (EW'(line_width_reg) > EW'(MAX_WIDTH))
        begin
            eff_width = EW'(MAX_WIDTH);
        end

        eff_count = disp_count_reg;
        if (disp_count_reg == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (disp_count_reg > COUNT_W'(MAX_DISP))
        begin
            eff_count = COUNT_W'(MAX_DISP);
        end
        if (EW'(eff_count) > eff_width)
        begin
            eff_count = eff_width[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        col_inc = EW'(column_reg) + EW'(1);
        if (col_inc >= eff_width)
        begin
            column_next = '0;
            slot_next   = '0;
        end
        else
        begin
            column_next = col_inc[CW-1:0];
            slot_next   = (slot_reg == DISP_W'(MAX_DISP - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    always_comb
    begin
        cmd.left_pixel  = in_item.left_pixel;
        cmd.right_pixel = in_item.right_pixel;
        cmd.slot        = slot_reg;
        cmd.near_col    = (EW'(column_reg) >= EW'(NEAR_COL_MAX)) ?
                          NEAR_COL_MAX : DISP_W'(column_reg);
        cmd.count       = eff_count;
        cmd.first_col   = (column_reg == '0);
    end

    assign threshold = threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RST;
            disp_count_reg <= DISP_COUNT_RST;
            line_width_reg <= LINE_WIDTH_RST;
            column_reg     <= '0;
            slot_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD:  threshold_reg  <= cfg_data[PIX_W-1:0];
                    CFG_DISP_COUNT: disp_count_reg <= cfg_data[COUNT_W-1:0];
                    CFG_LINE_WIDTH: line_width_reg <= cfg_data[LWIDTH_W-1:0];
                    default:        ;
                endcase
            end
            if (accept)
            begin
                column_reg <= column_next;
                slot_reg   <= slot_next;
            end
        end
    end

endmodule

>>> src/stca_back.sv
// Back part: takes commands, stores the left pixel in the history RAM and steps
// through the disparities, one RAM read and one cost a cycle while the output queue has room.
// Depends on stca_pkg and stca_ram.
module stca_back
    import stca_pkg::*;
#(
    parameter int MAX_DISP  = 64,
    parameter int OUT_DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    input  logic                         cmd_empty,
    output logic                         cmd_pop,
    input  logic [PIX_W-1:0]             threshold,
    input  logic [$clog2(OUT_DEPTH):0]   out_count,
    output logic                         out_push,
    output out_item_t                    out_item
);

    localparam int AW  = (MAX_DISP > 1) ? $clog2(MAX_DISP) : 1;
    localparam int OCW = $clog2(OUT_DEPTH) + 1;

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cur_reg;
    logic [DISP_W-1:0] d_reg;
    logic [DISP_W-1:0] d_next;
    logic [PIX_W-1:0]  row_first_reg;
    logic [PIX_W-1:0]  row_first_next;
    logic              b_valid_reg;
    logic [DISP_W-1:0] b_d_reg;
    logic              b_last_reg;
    logic              b_use_first_reg;

    logic              issue;
    logic              credit_ok;
    logic              last_d;
    logic [DISP_W:0]   addr_wide;
    logic [PIX_W-1:0]  ram_rdata;
    logic [PIX_W-1:0]  left_val;
    logic [PIX_W-1:0]  diff;

    assign credit_ok = (({1'b0, out_count} + (OCW+1)'(b_valid_reg)) < (OCW+1)'(OUT_DEPTH));
    assign last_d    = ((COUNT_W'(d_reg) + COUNT_W'(1)) == cur_reg.count);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (credit_ok && last_d)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop = 1'b0;
        issue   = 1'b0;
        unique case (state_reg)
            BK_IDLE: cmd_pop = !cmd_empty;
            BK_RUN:  issue   = credit_ok;
            default: ;
        endcase
    end

    always_comb
    begin
        d_next         = d_reg;
        row_first_next = row_first_reg;
        if (cmd_pop)
        begin
            d_next = '0;
            if (cmd.first_col)
            begin
                row_first_next = cmd.left_pixel;
            end
        end
        else if (issue)
        begin
            d_next = d_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (cur_reg.slot >= d_reg)
        begin
            addr_wide = {1'b0, cur_reg.slot} - {1'b0, d_reg};
        end
        else
        begin
            addr_wide = {1'b0, cur_reg.slot} + (DISP_W+1)'(MAX_DISP) - {1'b0, d_reg};
        end
    end

    stca_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_DISP)
    ) u_history (
        .clk   (clk),
        .we    (cmd_pop),
        .waddr (cmd.slot[AW-1:0]),
        .wdata (cmd.left_pixel),
        .re    (issue),
        .raddr (addr_wide[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        left_val = b_use_first_reg ? row_first_reg : ram_rdata;
        diff     = (cur_reg.right_pixel > left_val) ? cur_reg.right_pixel - left_val
                                                    : left_val - cur_reg.right_pixel;
        out_item.cost          = (diff > threshold) ? threshold : diff;
        out_item.disparity     = b_d_reg;
        out_item.last_of_pixel = b_last_reg;
    end

    assign out_push = b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            d_reg       <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            d_reg       <= d_next;
            b_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        row_first_reg <= row_first_next;
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (issue)
        begin
            b_d_reg         <= d_reg;
            b_last_reg      <= last_d;
            b_use_first_reg <= (cur_reg.near_col < d_reg);
        end
    end

`ifndef ASSERT_OFF
    a_result_fits: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> ({1'b0, out_count} < (OCW+1)'(OUT_DEPTH)))
        else $error("result pushed into a full output queue");

    a_disp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_RUN) |-> (COUNT_W'(d_reg) < cur_reg.count))
        else $error("disparity step beyond the count of the pixel");

    a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_pop && issue))
        else $error("history write and read issued together");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last_d) |=> (state_reg == BK_IDLE))
        else $error("sequencer did not stop after the last disparity");
`endif

endmodule

>>> src/stereo_truncated_ad_cost_volume.sv
// Truncated absolute-difference stereo matching cost, one cost per disparity.
// The back sequencer loads one queued command at a time, then issues one history
// RAM read and one cost per cycle while the output queue has room; the front
// accepts further requests into the command queue until it is full.
// Reset: asynchronous, clears counters, queues and configuration to defaults;
// the left history RAM is not cleared and is written before it is read.
module stereo_truncated_ad_cost_volume
    import stca_pkg::*;
#(
    parameter int MAX_DISP  = 64,
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  in_item_t              in_item,
    output logic                  full,
    input  logic                  pop,
    output out_item_t             out_item,
    output logic                  empty,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    cmd_t                       front_cmd;
    cmd_t                       back_cmd;
    logic                       cmd_full;
    logic                       cmd_empty;
    logic                       cmd_pop;
    logic                       accept;
    logic [PIX_W-1:0]           threshold;
    logic                       res_push;
    out_item_t                  res_item;
    logic [$clog2(OUT_DEPTH):0] out_count;
    logic [$bits(out_item_t)-1:0] out_word;

    assign cfg_ready = 1'b1;
    assign full      = cmd_full;
    assign accept    = push && !cmd_full;

    stca_front #(
        .MAX_DISP  (MAX_DISP),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .in_item   (in_item),
        .cmd       (front_cmd),
        .threshold (threshold)
    );

    stca_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (back_cmd),
        .empty (cmd_empty),
        .count ()
    );

    stca_back #(
        .MAX_DISP  (MAX_DISP),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .threshold (threshold),
        .out_count (out_count),
        .out_push  (res_push),
        .out_item  (res_item)
    );

    stca_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_item),
        .full  (),
        .pop   (pop),
        .rdata (out_word),
        .empty (empty),
        .count (out_count)
    );

    assign out_item = out_item_t'(out_word);

endmodule
